@@ hw/rtl/sf_pkg.sv @@
// Shared types and constants of the spectral flux block.
package sf_pkg;

    localparam int LOG_W  = 21;   // Q5.16 log2 value
    localparam int FRAC_W = 16;
    localparam int EXP_W  = 5;
    localparam int OUT_W  = 34;
    localparam int CNT_W  = 4;
    localparam int CFG_W  = 32;
    localparam int BINS_W = 11;
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_LOG = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUM = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BIN = 2'd2;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_BINS = 1'b1;

    localparam logic [MODE_W-1:0] MODE_RESET = MODE_SUM;
    localparam logic [BINS_W-1:0] BINS_RESET = 11'd1024;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOG,
        S_CALC,
        S_SQ,
        S_MUL,
        S_DCHK,
        S_DIV,
        S_EMIT
    } sf_state_t;

endpackage

@@ hw/rtl/spectral_flux.sv @@
// Spectral flux onset detector: top level with history store and control.
//
// Spectrum magnitudes arrive one item per bin, frame after frame. Mode 0
// takes a Q5.16 log2 of each magnitude, sums the squared differences to the
// previous frame over bins 1 to N-1 and gives sum/(max*N) as a Q0.16 fraction
// at frame end. Mode 1 (and mode 3) gives the sum of positive raw differences
// over bins 1 to N-1 at frame end, saturated to 34 bits. Mode 2 gives one item
// per bin with the rectified difference. The previous frame lives in one RAM
// with registered read; each bin that is stored is read, updated and written
// back before the next item is taken, so no forwarding is needed. Steps: a
// mode 2 bin and the last bin of a mode 1 frame go through accept, compute
// and output, other mode 1 bins through accept and compute, and bin 0 in
// modes 0 and 1, which is not stored, only through accept. A mode 0 bin goes
// through accept, the 16-step log2 squaring loop on its one 32x32 multiplier,
// compute and square; the mode 0 frame end adds the denominator product, the
// 16-step restoring divider and the output. After reset, and whenever
// forget_history is set on bin 0, the RAM is cleared by a pass over all
// MAX_BINS addresses during which no item is taken; configuration writes are
// accepted at any time. The output item sits in a register, so the next item
// is accepted while a result waits to be taken.
module spectral_flux #(
    parameter int MAX_BINS    = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [sf_pkg::CFG_W-1:0]  pwdata,
    output logic [sf_pkg::CFG_W-1:0]  prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [SAMPLE_BITS-1:0]    magnitude,
    input  logic                      forget_history,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [sf_pkg::OUT_W-1:0]  flux_value,
    output logic                      frame_end
);

    import sf_pkg::*;

    localparam int STORE_W = (SAMPLE_BITS > LOG_W) ? SAMPLE_BITS : LOG_W;
    localparam int POS_W   = $clog2(MAX_BINS);
    localparam int N_W     = $clog2(MAX_BINS + 1);
    localparam int SQ_W    = 2 * STORE_W;
    localparam int SUM_W   = SQ_W + POS_W + 1;
    localparam int DEN_W   = SQ_W + N_W;
    localparam int CW      = (SUM_W > DEN_W) ? SUM_W : DEN_W;
    localparam logic [POS_W-1:0] LAST_ADDR = POS_W'(MAX_BINS - 1);
    localparam logic [OUT_W-1:0] OUT_MAX   = {OUT_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_LAST  = {CNT_W{1'b1}};

    // Control state.
    sf_state_t         state_reg, state_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  clr_reg, clr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              fdone_reg, fdone_next;
    logic              out_valid_reg, out_valid_next;
    logic [MODE_W-1:0] mode_reg;
    logic [BINS_W-1:0] bins_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SQ_W-1:0]   max_reg, max_next;

    // Datapath registers.
    logic [SAMPLE_BITS-1:0] xm_reg, xm_next;
    logic [MODE_W-1:0]      xmode_reg, xmode_next;
    logic [POS_W-1:0]       xpos_reg, xpos_next;
    logic                   xlast_reg, xlast_next;
    logic [N_W-1:0]         xn_reg, xn_next;
    logic [31:0]            y_reg, y_next;
    logic [EXP_W-1:0]       e_reg, e_next;
    logic [FRAC_W-1:0]      frac_reg, frac_next;
    logic [STORE_W-1:0]     d_reg, d_next;
    logic [DEN_W-1:0]       den_reg, den_next;
    logic [CW:0]            rem_reg, rem_next;
    logic [FRAC_W-1:0]      q_reg, q_next;
    logic [OUT_W-1:0]       res_reg, res_next;
    logic [OUT_W-1:0]       oval_reg, oval_next;
    logic                   olast_reg, olast_next;

    // RAM port.
    logic               ram_we, ram_re;
    logic [POS_W-1:0]   ram_waddr;
    logic [STORE_W-1:0] ram_wdata, ram_rdata;

    // Combinational helpers.
    logic              cfg_wr;
    logic [N_W-1:0]    n_sat;
    logic              in_last;
    logic              forget_now;
    logic [31:0]       m32;
    logic [EXP_W-1:0]  lead;
    logic [63:0]       prod;
    logic [32:0]       y2;
    logic [STORE_W-1:0] prev, m_ext, l_ext;
    logic [SQ_W-1:0]   sq;
    logic [CW:0]       r2;
    logic [CW:0]       den_ext;

    sf_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_BINS)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_MODE: prdata = CFG_W'(mode_reg);
            REG_BINS: prdata = CFG_W'(bins_reg);
            default:  prdata = '0;
        endcase
    end

    // The frame length is clamped to the range the store supports.
    always_comb
    begin
        if (32'(bins_reg) < 32'd2)
        begin
            n_sat = N_W'(2);
        end
        else if (32'(bins_reg) > 32'(MAX_BINS))
        begin
            n_sat = N_W'(MAX_BINS);
        end
        else
        begin
            n_sat = N_W'(bins_reg);
        end
    end

    assign in_last    = (32'(pos_reg) + 32'd1) >= 32'(n_sat);
    assign forget_now = (pos_reg == '0) && forget_history && !fdone_reg;
    assign in_ready   = (state_reg == S_IDLE) && !forget_now;

    // Leading one of the magnitude; a zero is taken as one.
    assign m32 = (magnitude == '0) ? 32'd1 : 32'(magnitude);

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (m32[i])
            begin
                lead = EXP_W'(i);
            end
        end
    end

    assign prod    = 64'(y_reg) * 64'(y_reg);
    assign y2      = prod[63:31];
    assign prev    = ram_rdata;
    assign m_ext   = STORE_W'(xm_reg);
    assign l_ext   = STORE_W'({e_reg, frac_reg});
    assign sq      = SQ_W'(d_reg) * SQ_W'(d_reg);
    assign r2      = {rem_reg[CW-1:0], 1'b0};
    assign den_ext = (CW + 1)'(den_reg);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        fdone_next     = fdone_reg;
        out_valid_next = out_valid_reg && !out_ready;
        sum_next       = sum_reg;
        max_next       = max_reg;
        xm_next        = xm_reg;
        xmode_next     = xmode_reg;
        xpos_next      = xpos_reg;
        xlast_next     = xlast_reg;
        xn_next        = xn_reg;
        y_next         = y_reg;
        e_next         = e_reg;
        frac_next      = frac_reg;
        d_next         = d_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        res_next       = res_reg;
        oval_next      = oval_reg;
        olast_next     = olast_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = xpos_reg;
        ram_wdata      = '0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    clr_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && forget_now)
                begin
                    fdone_next = 1'b1;
                    state_next = S_CLEAR;
                end
                else if (in_valid)
                begin
                    fdone_next = 1'b0;
                    ram_re     = 1'b1;
                    xm_next    = magnitude;
                    xmode_next = mode_reg;
                    xpos_next  = pos_reg;
                    xlast_next = in_last;
                    xn_next    = n_sat;
                    pos_next   = in_last ? '0 : pos_reg + 1'b1;
                    y_next     = m32 << (5'd31 - lead);
                    e_next     = lead;
                    frac_next  = '0;
                    cnt_next   = '0;
                    if (pos_reg == '0)
                    begin
                        sum_next = '0;
                        max_next = '0;
                    end
                    if (mode_reg == MODE_BIN)
                    begin
                        state_next = S_CALC;
                    end
                    else if (pos_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (mode_reg == MODE_LOG)
                    begin
                        state_next = S_LOG;
                    end
                    else
                    begin
                        state_next = S_CALC;
                    end
                end
            end
            S_LOG:
            begin
                // One squaring step yields one fraction bit, top first.
                if (y2[32])
                begin
                    y_next    = y2[32:1];
                    frac_next = {frac_reg[FRAC_W-2:0], 1'b1};
                end
                else
                begin
                    y_next    = y2[31:0];
                    frac_next = {frac_reg[FRAC_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                ram_we = 1'b1;
                if (xmode_reg == MODE_BIN)
                begin
                    ram_wdata  = m_ext;
                    res_next   = (m_ext > prev) ? OUT_W'(m_ext - prev) : '0;
                    state_next = S_EMIT;
                end
                else if (xmode_reg == MODE_LOG)
                begin
                    ram_wdata  = l_ext;
                    d_next     = (l_ext >= prev) ? (l_ext - prev) : (prev - l_ext);
                    state_next = S_SQ;
                end
                else
                begin
                    ram_wdata = m_ext;
                    if (m_ext >= prev)
                    begin
                        sum_next = sum_reg + SUM_W'(m_ext - prev);
                    end
                    if (sum_next > SUM_W'(OUT_MAX))
                    begin
                        res_next = OUT_MAX;
                    end
                    else
                    begin
                        res_next = OUT_W'(sum_next);
                    end
                    state_next = xlast_reg ? S_EMIT : S_IDLE;
                end
            end
            S_SQ:
            begin
                sum_next = sum_reg + SUM_W'(sq);
                if (sq > max_reg)
                begin
                    max_next = sq;
                end
                state_next = xlast_reg ? S_MUL : S_IDLE;
            end
            S_MUL:
            begin
                den_next   = DEN_W'(max_reg) * DEN_W'(xn_reg);
                state_next = S_DCHK;
            end
            S_DCHK:
            begin
                cnt_next = '0;
                q_next   = '0;
                rem_next = (CW + 1)'(sum_reg);
                if (max_reg == '0)
                begin
                    res_next   = '0;
                    state_next = S_EMIT;
                end
                else if ((CW + 1)'(sum_reg) >= den_ext)
                begin
                    res_next   = OUT_W'({FRAC_W{1'b1}});
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                if (r2 >= den_ext)
                begin
                    rem_next = r2 - den_ext;
                    q_next   = {q_reg[FRAC_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = r2;
                    q_next   = {q_reg[FRAC_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    res_next   = OUT_W'(q_next);
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    oval_next      = res_reg;
                    olast_next     = xlast_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            pos_reg       <= '0;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            fdone_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            max_reg       <= '0;
            mode_reg      <= MODE_RESET;
            bins_reg      <= BINS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            fdone_reg     <= fdone_next;
            out_valid_reg <= out_valid_next;
            sum_reg       <= sum_next;
            max_reg       <= max_next;
            if (cfg_wr && paddr[2] == REG_MODE)
            begin
                mode_reg <= pwdata[MODE_W-1:0];
            end
            if (cfg_wr && paddr[2] == REG_BINS)
            begin
                bins_reg <= pwdata[BINS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        xm_reg    <= xm_next;
        xmode_reg <= xmode_next;
        xpos_reg  <= xpos_next;
        xlast_reg <= xlast_next;
        xn_reg    <= xn_next;
        y_reg     <= y_next;
        e_reg     <= e_next;
        frac_reg  <= frac_next;
        d_reg     <= d_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        res_reg   <= res_next;
        oval_reg  <= oval_next;
        olast_reg <= olast_next;
    end

    assign out_valid  = out_valid_reg;
    assign flux_value = oval_reg;
    assign frame_end  = olast_reg;

    // The divider remainder always stays below the denominator.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < den_ext))
        else $error("divider remainder not below denominator");

    // The store is written only by the clearing pass or a bin update.
    a_ram_we: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_CALC))
        else $error("store written outside clear or update");

    // A normalized flux is a Q0.16 fraction.
    a_log_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && xmode_reg == MODE_LOG) |-> (res_reg[OUT_W-1:FRAC_W] == '0))
        else $error("normalized flux exceeds 16 bits");

    // An item is never taken into a clearing pass of the store.
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_CLEAR))
        else $error("item accepted into a clearing pass");

endmodule

@@ hw/rtl/sf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module sf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ test/spectral_flux_tb.sv @@
// Self-checking testbench of the spectral flux onset detector.
module spectral_flux_tb;
    import sf_pkg::*;

    localparam int MAX_BINS = 1024;
    localparam int SAMPLE_BITS = 24;
    localparam logic [2:0] ADDR_MODE = 3'd0;
    localparam logic [2:0] ADDR_BINS = 3'd4;
    localparam logic [OUT_W-1:0] OUT_SAT = {OUT_W{1'b1}};

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] magnitude;
        logic                   forget;
    } bin_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] flux;
        logic             last;
    } flux_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [CFG_W-1:0] pwdata = '0;
    logic [CFG_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [SAMPLE_BITS-1:0] magnitude = '0;
    logic forget_history = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [OUT_W-1:0] flux_value;
    logic frame_end;

    spectral_flux #(.MAX_BINS(MAX_BINS), .SAMPLE_BITS(SAMPLE_BITS)) dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .magnitude(magnitude), .forget_history(forget_history),
        .out_valid(out_valid), .out_ready(out_ready),
        .flux_value(flux_value), .frame_end(frame_end)
    );

    always #6 clk = ~clk;

    // Shadow copy of the block's state, advanced once per accepted item.
    logic [31:0] hist_store [MAX_BINS];
    logic [63:0] acc_sum;
    logic [63:0] acc_max;
    int unsigned bin_idx;
    logic [1:0] cur_mode;
    logic [10:0] cur_bins;

    bin_item_t pending_bins[$];
    flux_result_t expected_flux[$];
    int errors = 0;
    int sent_count = 0;

    // Set at a rising edge at which the offered item was taken.
    bit in_accepted = 1'b0;

    // Sender pacing and the receiver's stall pattern.
    int burst_left = 0;
    int gap_left = 0;
    bit hold_input = 1'b0;
    bit recv_holdoff = 1'b0;
    int holdoff_cycles = 0;
    int stall_phase = 0;

    function automatic logic [20:0] fixed_log2(input logic [31:0] m);
        int unsigned e;
        logic [15:0] frac;
        logic [63:0] y;
        e = 0;
        frac = '0;
        if (m == 0)
            m = 1;
        while (e < 31 && (m >> (e + 1)) != 0)
            e++;
        y = 64'(m) << (31 - e);
        for (int i = 15; i >= 0; i--)
        begin
            y = (y * y) >> 31;
            if (y >= (64'd1 << 32))
            begin
                frac[i] = 1'b1;
                y = y >> 1;
            end
        end
        return {5'(e), frac};
    endfunction

    function automatic logic [15:0] flux_ratio(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] r;
        logic [15:0] q;
        r = num;
        q = '0;
        if (den == 0)
            return 16'd0;
        if (r >= den)
            return 16'hFFFF;
        for (int i = 0; i < 16; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    task automatic predict_bin(input bin_item_t it);
        int unsigned n;
        int unsigned pos;
        int unsigned idx;
        bit last;
        logic [31:0] m;
        logic [31:0] lg;
        logic [31:0] prev;
        logic [63:0] d;
        logic [63:0] sq;
        logic [63:0] value;
        flux_result_t res;
        n = cur_bins;
        if (n < 2)
            n = 2;
        if (n > MAX_BINS)
            n = MAX_BINS;
        pos = bin_idx;
        m = 32'(it.magnitude);
        last = (pos + 1 >= n);
        idx = (pos < MAX_BINS) ? pos : MAX_BINS - 1;
        value = '0;
        if (pos == 0)
        begin
            if (it.forget)
                foreach (hist_store[i])
                    hist_store[i] = '0;
            acc_sum = '0;
            acc_max = '0;
        end
        prev = hist_store[idx];
        if (cur_mode == MODE_BIN)
        begin
            value = (m > prev) ? 64'(m - prev) : 64'd0;
            hist_store[idx] = m;
        end
        else if (cur_mode == MODE_LOG)
        begin
            if (pos >= 1)
            begin
                lg = 32'(fixed_log2(m));
                d = (lg >= prev) ? 64'(lg - prev) : 64'(prev - lg);
                sq = d * d;
                acc_sum += sq;
                if (sq > acc_max)
                    acc_max = sq;
                hist_store[idx] = lg;
            end
        end
        else if (pos >= 1)
        begin
            if (m >= prev)
                acc_sum += 64'(m - prev);
            hist_store[idx] = m;
        end
        bin_idx = last ? 0 : pos + 1;
        if (cur_mode != MODE_BIN)
        begin
            if (!last)
                return;
            if (cur_mode == MODE_LOG)
                value = (acc_max == 0) ? 64'd0 : 64'(flux_ratio(acc_sum, acc_max * 64'(n)));
            else
                value = (acc_sum > 64'(OUT_SAT)) ? 64'(OUT_SAT) : acc_sum;
        end
        res.flux = value[OUT_W-1:0];
        res.last = last;
        expected_flux.push_back(res);
    endtask

    // Driver: takes items from the pending queue in bursts with random gaps.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_accepted)
            begin
                // Hold the item until the block takes it.
            end
            else if (pending_bins.size() != 0 && !hold_input && gap_left == 0)
            begin
                bin_item_t it;
                it = pending_bins.pop_front();
                magnitude <= it.magnitude;
                forget_history <= it.forget;
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
        end
    end

    // Receiver stall pattern: random stalls in some phases, none in others, and
    // an optional long hold-off counted here.
    always @(negedge clk)
    begin
        stall_phase <= (stall_phase + 1) % 400;
        if (holdoff_cycles > 0)
        begin
            out_ready <= 1'b0;
            holdoff_cycles <= holdoff_cycles - 1;
        end
        else if (recv_holdoff)
        begin
            out_ready <= 1'b0;
            holdoff_cycles <= 300;
            recv_holdoff <= 1'b0;
        end
        else if (stall_phase < 150)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    // Monitor: predicts on accepted items and checks accepted results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_accepted <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                predict_bin('{magnitude: magnitude, forget: forget_history});
                sent_count <= sent_count + 1;
            end
            if (out_valid && out_ready)
            begin
                if (expected_flux.size() == 0)
                begin
                    $display("%0t: unexpected result flux=%0d end=%0b",
                             $time, flux_value, frame_end);
                    errors++;
                end
                else
                begin
                    flux_result_t exp_r;
                    exp_r = expected_flux.pop_front();
                    if (flux_value !== exp_r.flux)
                    begin
                        $display("%0t: flux_value expected %0d actual %0d",
                                 $time, exp_r.flux, flux_value);
                        errors++;
                    end
                    if (frame_end !== exp_r.last)
                    begin
                        $display("%0t: frame_end expected %0b actual %0b",
                                 $time, exp_r.last, frame_end);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == ADDR_MODE)
            cur_mode = data[1:0];
        else
            cur_bins = data[10:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Waits until all queued items went in and all results came out, then lets
    // a frame-end divide and a possible store clear finish.
    task automatic drain;
        while (pending_bins.size() != 0 || in_valid || expected_flux.size() != 0)
            @(posedge clk);
        repeat (MAX_BINS + 200)
            @(posedge clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] rand_mag();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return '0;
            1: return '1;
            2: return SAMPLE_BITS'($urandom_range(0, 15));
            3: return SAMPLE_BITS'(1) << $urandom_range(0, SAMPLE_BITS - 1);
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // Queues whole frames; a forget flag lands on bin 0 now and then, and
    // sometimes on other bins where it must be ignored.
    task automatic queue_frames(input int frames, input int n);
        bin_item_t it;
        for (int f = 0; f < frames; f++)
            for (int b = 0; b < n; b++)
            begin
                it.magnitude = rand_mag();
                it.forget = (b == 0) ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 15) == 0);
                pending_bins.push_back(it);
            end
    endtask

    initial
    begin
        int unsigned n;
        int unsigned mode;
        foreach (hist_store[i])
            hist_store[i] = '0;
        acc_sum = '0;
        acc_max = '0;
        bin_idx = 0;
        cur_mode = MODE_RESET;
        cur_bins = BINS_RESET;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: short frames at the extremes of the magnitude in each mode.
        reg_write(ADDR_BINS, 32'd2);
        hold_input = 1'b1;
        pending_bins.push_back('{magnitude: '1, forget: 1'b0});
        pending_bins.push_back('{magnitude: '1, forget: 1'b0});
        pending_bins.push_back('{magnitude: '0, forget: 1'b0});
        pending_bins.push_back('{magnitude: '0, forget: 1'b1});
        hold_input = 1'b0;
        drain();
        reg_write(ADDR_MODE, 32'(MODE_BIN));
        pending_bins.push_back('{magnitude: 24'd5, forget: 1'b1});
        pending_bins.push_back('{magnitude: '1, forget: 1'b0});
        pending_bins.push_back('{magnitude: 24'd3, forget: 1'b0});
        pending_bins.push_back('{magnitude: '0, forget: 1'b0});
        drain();
        reg_write(ADDR_MODE, 32'(MODE_LOG));
        reg_write(ADDR_BINS, 32'd3);
        // All-zero magnitudes give a zero maximum, hence a zero flux.
        pending_bins.push_back('{magnitude: '0, forget: 1'b1});
        pending_bins.push_back('{magnitude: '0, forget: 1'b0});
        pending_bins.push_back('{magnitude: '0, forget: 1'b0});
        pending_bins.push_back('{magnitude: '1, forget: 1'b0});
        pending_bins.push_back('{magnitude: '1, forget: 1'b0});
        pending_bins.push_back('{magnitude: 24'd1, forget: 1'b0});
        drain();
        // Mode 3 behaves as mode 1; out-of-range frame lengths saturate.
        reg_write(ADDR_MODE, 32'd3);
        reg_write(ADDR_BINS, 32'd0);
        pending_bins.push_back('{magnitude: 24'd9, forget: 1'b0});
        pending_bins.push_back('{magnitude: '1, forget: 1'b0});
        drain();
        reg_write(ADDR_BINS, 32'h7FF);
        reg_write(ADDR_MODE, 32'(MODE_BIN));
        queue_frames(1, 3);
        drain();
        reg_write(ADDR_BINS, 32'd1024);
        reg_write(ADDR_MODE, 32'(MODE_SUM));
        queue_frames(1, 1024);
        drain();

        // Long receiver hold-off while the sender keeps offering items.
        reg_write(ADDR_MODE, 32'(MODE_BIN));
        reg_write(ADDR_BINS, 32'd4);
        recv_holdoff = 1'b1;
        queue_frames(10, 4);
        drain();

        // Random phases with random settings and mostly small frames.
        while (sent_count < 1400)
        begin
            mode = $urandom_range(0, 3);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 40) : $urandom_range(2, 8);
            reg_write(ADDR_MODE, 32'(mode));
            reg_write(ADDR_BINS, 32'(n));
            queue_frames((mode == MODE_LOG) ? $urandom_range(1, 3) : $urandom_range(2, 8), n);
            drain();
        end

        if (errors == 0)
            $display("spectral_flux regression: pass");
        else
            $display("spectral_flux regression: fail");
        $finish;
    end

    initial
    begin
        #60000000;
        $display("spectral_flux regression: fail");
        $finish;
    end

endmodule
